>>> src/set_assoc_cache_lru_age_macros.svh
// Assertion macros shared by the cache RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef SET_ASSOC_CACHE_LRU_AGE_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_AGE_MACROS_SVH

// Property holds at every edge outside reset.
`define SACLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SACLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sacla_pkg.sv
// Shared constants and types of the set-associative cache.
// No dependencies.
`timescale 1ns / 1ps

package sacla_pkg;

  localparam int unsigned WAYS        = 8;
  localparam int unsigned LINE_BYTES  = 32;
  localparam int unsigned TOTAL_BYTES = 32768;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned DATA_BITS   = 32;

  localparam int unsigned SETS      = TOTAL_BYTES / (LINE_BYTES * WAYS);
  localparam int unsigned WORDS     = LINE_BYTES / 4;
  localparam int unsigned OFF_BITS  = $clog2(LINE_BYTES);
  localparam int unsigned SET_BITS  = $clog2(SETS);
  localparam int unsigned WORD_BITS = $clog2(WORDS);
  localparam int unsigned TAG_W     = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int unsigned WAY_BITS  = $clog2(WAYS);
  localparam int unsigned AGE_BITS  = $clog2(WAYS);

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // One way of a set; wmask marks words written since reset.
  typedef struct packed {
    logic                 valid;
    logic [TAG_W-1:0]     tag;
    logic [AGE_BITS-1:0]  age;
    logic [WORDS-1:0]     wmask;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                word_valid;
    row_t                new_row;
  } lookup_t;

endpackage

>>> src/sacla_ram.sv
// Generic simple dual-port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sacla_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> src/sacla_lookup.sv
// Tag match, victim choice and age update for one set row.
// Depends on sacla_pkg.
`timescale 1ns / 1ps

module sacla_lookup (
  input  sacla_pkg::row_t                     row_i,
  input  logic [sacla_pkg::TAG_W-1:0]         tag_i,
  input  logic [sacla_pkg::WORD_BITS-1:0]     word_i,
  input  logic                                write_i,
  output sacla_pkg::lookup_t                  lk_o
);
  import sacla_pkg::*;

  always_comb begin
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                any_inv;
    logic [WAY_BITS-1:0] inv_way;
    logic [WAY_BITS-1:0] old_way;
    logic [WAY_BITS-1:0] way;
    logic [AGE_BITS-1:0] cur_age;
    row_t                nrow;

    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    old_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && row_i[i].valid && row_i[i].tag == tag_i) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(i);
      end
      if (!any_inv && !row_i[i].valid) begin
        any_inv = 1'b1;
        inv_way = WAY_BITS'(i);
      end
      if (row_i[i].age == AGE_BITS'(WAYS - 1)) begin
        old_way = WAY_BITS'(i);
      end
    end

    if (hit) begin
      way = hit_way;
    end else if (any_inv) begin
      way = inv_way;
    end else begin
      way = old_way;
    end

    // Ages younger than the touched way move up by one.
    cur_age = row_i[way].age;
    nrow    = row_i;
    for (int i = 0; i < WAYS; i++) begin
      if (row_i[i].age < cur_age) begin
        nrow[i].age = row_i[i].age + AGE_BITS'(1);
      end
    end
    nrow[way].age = '0;
    if (!hit) begin
      nrow[way].valid = 1'b1;
      nrow[way].tag   = tag_i;
    end
    if (write_i || !hit) begin
      nrow[way].wmask[word_i] = 1'b1;
    end

    lk_o.hit        = hit;
    lk_o.way        = way;
    lk_o.word_valid = row_i[way].wmask[word_i];
    lk_o.new_row    = nrow;
  end

endmodule

>>> src/set_assoc_cache_lru_age.sv
// Top level of the 8-way set-associative cache with age-based replacement.
// Depends on sacla_pkg, sacla_ram, sacla_lookup and the assertion macros.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request transaction:
//   req_type_i (0 read, 1 write), byte address_i, write_data_i, and
//   fill_data_i, the memory word installed on a read miss.
//   Output channel (out_valid_o / out_stall_i) returns one result
//   transaction per request: read_data_o, hit_o and done_code_o.
//   A new request is taken only once the last one has left the lookup
//   state. The accepting edge reads the set row (valid, tag, age and word
//   marks of all ways) from the row memory; the lookup state runs the
//   lookup, writes the row back and starts the word memory access. The
//   word read finishes while the next request is accepted.
//   Receiver stall: the result holds in the output register; one more
//   result may wait internally, then the input channel stalls.
//   Reset: async, active low. Per-set init flops clear at once, so the row
//   memory reads as all-zero until a set is first written; the per-word
//   marks in each row make never-written words read as zero. No clearing
//   pass is needed; requests are taken right after reset.
`timescale 1ns / 1ps
`include "set_assoc_cache_lru_age_macros.svh"

module set_assoc_cache_lru_age (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [sacla_pkg::ADDR_BITS-1:0]      address_i,
  input  logic signed [sacla_pkg::DATA_BITS-1:0] write_data_i,
  input  logic signed [sacla_pkg::DATA_BITS-1:0] fill_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sacla_pkg::DATA_BITS-1:0] read_data_o,
  output logic                                 hit_o,
  output logic                                 done_code_o
);
  import sacla_pkg::*;

  localparam int unsigned ROW_BITS  = $bits(row_t);
  localparam int unsigned WADR_BITS = WAY_BITS + SET_BITS + WORD_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e state_q;

  // Request registers.
  logic                 req_type_q;
  logic [TAG_W-1:0]     req_tag_q;
  logic [SET_BITS-1:0]  req_set_q;
  logic [WORD_BITS-1:0] req_word_q;
  logic                 req_high_q;
  logic [DATA_BITS-1:0] req_wdata_q;
  logic [DATA_BITS-1:0] req_fdata_q;

  // Result waiting for the word memory read data.
  logic                 pend_q;
  logic                 pend_hit_q;
  logic                 pend_type_q;
  logic                 pend_use_mem_q;
  logic [DATA_BITS-1:0] pend_val_q;

  logic [SETS-1:0]      row_init_q;
  logic                 row_init_rd_q;

  logic                 accept;
  logic                 out_free;
  logic                 req_write;
  logic                 word_we;
  logic                 word_re;
  logic [ROW_BITS-1:0]  row_rdata;
  logic [DATA_BITS-1:0] word_rdata;
  logic [SET_BITS-1:0]  in_set;
  row_t                 row_cur;
  lookup_t              lk;

  assign in_set   = address_i[OFF_BITS+SET_BITS-1:OFF_BITS];
  assign out_free = !out_valid_o || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && (!pend_q || out_free));
  assign accept   = in_valid_i && !in_stall_o;
  assign req_write = (req_type_q == REQ_WRITE);

  // A set never written since reset reads as all-zero.
  assign row_cur = row_init_rd_q ? row_t'(row_rdata) : row_t'('0);

  sacla_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(SETS)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_LOOK),
    .waddr_i(req_set_q),
    .wdata_i(lk.new_row),
    .re_i   (accept),
    .raddr_i(in_set),
    .rdata_o(row_rdata)
  );

  sacla_lookup u_lookup (
    .row_i  (row_cur),
    .tag_i  (req_tag_q),
    .word_i (req_word_q),
    .write_i(req_write),
    .lk_o   (lk)
  );

  // Writes and read misses store a word; read hits fetch one.
  assign word_we = (state_q == ST_LOOK) && (req_write || !lk.hit);
  assign word_re = (state_q == ST_LOOK) && !req_write && lk.hit;

  sacla_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(WAYS * SETS * WORDS)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (word_we),
    .waddr_i(WADR_BITS'({lk.way, req_set_q, req_word_q})),
    .wdata_i(req_write ? req_wdata_q : req_fdata_q),
    .re_i   (word_re),
    .raddr_i(WADR_BITS'({lk.way, req_set_q, req_word_q})),
    .rdata_o(word_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q    <= '0;
      row_init_rd_q <= 1'b0;
    end else begin
      if (accept) begin
        row_init_rd_q <= row_init_q[in_set];
      end
      if (state_q == ST_LOOK) begin
        row_init_q[req_set_q] <= 1'b1;
      end
    end
  end

  // Request capture: payload only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q  <= req_type_i;
      req_tag_q   <= address_i[ADDR_BITS-1:OFF_BITS+SET_BITS];
      req_set_q   <= in_set;
      req_word_q  <= address_i[OFF_BITS-1:2];
      req_high_q  <= (address_i >= ADDR_BITS'(TOTAL_BYTES));
      req_wdata_q <= write_data_i;
      req_fdata_q <= fill_data_i;
    end
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pend_q         <= 1'b0;
      pend_hit_q     <= 1'b0;
      pend_type_q    <= REQ_READ;
      pend_use_mem_q <= 1'b0;
      pend_val_q     <= '0;
      out_valid_o    <= 1'b0;
      read_data_o    <= '0;
      hit_o          <= 1'b0;
      done_code_o    <= REQ_READ;
    end else begin
      if (pend_q && out_free) begin
        out_valid_o <= 1'b1;
        read_data_o <= pend_use_mem_q ? word_rdata : pend_val_q;
        hit_o       <= pend_hit_q;
        done_code_o <= pend_type_q;
        pend_q      <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          pend_q         <= 1'b1;
          pend_hit_q     <= lk.hit;
          pend_type_q    <= req_type_q;
          // Hit reads of never-written words and high addresses give zero.
          pend_use_mem_q <= !req_write && lk.hit && lk.word_valid && !req_high_q;
          pend_val_q     <= (!req_write && !lk.hit && !req_high_q) ? req_fdata_q : '0;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `SACLA_ASSERT_NEXT(a_accept_to_look, accept, state_q == ST_LOOK, "accept did not start lookup")
  `SACLA_ASSERT_NEXT(a_look_sets_pend, state_q == ST_LOOK, pend_q, "lookup left no result")
  `SACLA_ASSERT_NEXT(a_pend_held, pend_q && out_valid_o && out_stall_i, pend_q, "pending result lost")
  `SACLA_ASSERT(a_hit_way_valid, (state_q == ST_LOOK && lk.hit) |-> row_cur[lk.way].valid, "hit on invalid way")
  `SACLA_ASSERT(a_touched_age0, (state_q == ST_LOOK) |-> (lk.new_row[lk.way].age == '0), "touched way not youngest")

endmodule

>>> tb/tb_set_assoc_cache_lru_age.sv
// Self-checking testbench for the 8-way set-associative cache with age-based replacement.
// Depends on sacla_pkg and set_assoc_cache_lru_age; a shadow cache predicts each result.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_age;
  import sacla_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 10;

  // One result transaction as the block returns it.
  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic                 hit;
    logic                 done;
  } cache_resp_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        req_type_i;
  logic [ADDR_BITS-1:0]        address_i;
  logic signed [DATA_BITS-1:0] write_data_i;
  logic signed [DATA_BITS-1:0] fill_data_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [DATA_BITS-1:0] read_data_o;
  logic                        hit_o;
  logic                        done_code_o;

  set_assoc_cache_lru_age u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .fill_data_i  (fill_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .hit_o        (hit_o),
    .done_code_o  (done_code_o)
  );

  // Shadow copy of the cache state, indexed [way][set].
  logic                 shadow_valid [WAYS][SETS];
  logic [TAG_W-1:0]     shadow_tag   [WAYS][SETS];
  logic [AGE_BITS-1:0]  shadow_age   [WAYS][SETS];
  logic [DATA_BITS-1:0] shadow_word  [WAYS][SETS][WORDS];

  cache_resp_t expected_resp [$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int error_cnt;
  int cycle_cnt;
  int read_cnt, write_cnt, hit_cnt, high_read_cnt, resp_cnt;

  // ---------------------------------------------------------------------------
  // Clock, reset and cycle budget
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Runaway guard: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_cnt,
               expected_resp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shadow cache: one access, returns the result transaction it causes.
  // ---------------------------------------------------------------------------
  function automatic cache_resp_t predict_access(input logic                 req,
                                                 input logic [ADDR_BITS-1:0] addr,
                                                 input logic [DATA_BITS-1:0] wdata,
                                                 input logic [DATA_BITS-1:0] fdata);
    logic [TAG_W-1:0]     tag_v;
    logic [SET_BITS-1:0]  set_v;
    logic [WORD_BITS-1:0] word_v;
    logic [AGE_BITS-1:0]  cur_age;
    logic                 found;
    logic                 free_found;
    int                   way;
    int                   oldest;
    cache_resp_t          resp;

    tag_v  = addr[OFF_BITS+SET_BITS +: TAG_W];
    set_v  = addr[OFF_BITS +: SET_BITS];
    word_v = addr[2 +: WORD_BITS];
    found  = 1'b0;
    way    = 0;
    resp   = '0;

    for (int i = 0; i < WAYS; i++) begin
      if (!found && shadow_valid[i][set_v] && shadow_tag[i][set_v] == tag_v) begin
        found = 1'b1;
        way   = i;
      end
    end

    // Victim: first free way, else the last way at maximum age, else way 0.
    if (!found) begin
      free_found = 1'b0;
      oldest     = 0;
      for (int i = 0; i < WAYS; i++) begin
        if (!free_found) begin
          if (!shadow_valid[i][set_v]) begin
            free_found = 1'b1;
            way        = i;
          end else if (shadow_age[i][set_v] == AGE_BITS'(WAYS - 1)) begin
            oldest = i;
          end
        end
      end
      if (!free_found) way = oldest;
    end

    if (req == REQ_WRITE) begin
      shadow_word[way][set_v][word_v] = wdata;
    end else if (found) begin
      resp.data = shadow_word[way][set_v][word_v];
    end else begin
      shadow_word[way][set_v][word_v] = fdata;
      resp.data = fdata;
    end

    if (!found) begin
      shadow_tag[way][set_v]   = tag_v;
      shadow_valid[way][set_v] = 1'b1;
    end

    // Age refresh: ways younger than the touched one grow older by one.
    cur_age = shadow_age[way][set_v];
    for (int i = 0; i < WAYS; i++) begin
      if (shadow_age[i][set_v] < cur_age) shadow_age[i][set_v] = shadow_age[i][set_v] + 1'b1;
    end
    shadow_age[way][set_v] = '0;

    // Writes and reads beyond the cache size return zero data.
    if (req == REQ_WRITE || addr >= ADDR_BITS'(TOTAL_BYTES)) resp.data = '0;
    resp.hit  = found;
    resp.done = req;

    if (req == REQ_WRITE) write_cnt++;
    else read_cnt++;
    if (found) hit_cnt++;
    if (req == REQ_READ && addr >= ADDR_BITS'(TOTAL_BYTES)) high_read_cnt++;
    return resp;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one transaction, with a random idle gap in front of it.
  // Valid stays high after acceptance so back-to-back requests need no gap.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic                 req,
                          input logic [ADDR_BITS-1:0] addr,
                          input logic [DATA_BITS-1:0] wdata,
                          input logic [DATA_BITS-1:0] fdata);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_type_i   <= req;
    address_i    <= addr;
    write_data_i <= wdata;
    fill_data_i  <= fdata;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_resp.push_back(predict_access(req, addr, wdata, fdata));
  endtask

  // Sender goes quiet until every outstanding result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_resp.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, plus a long hold-off when requested.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Scoreboard: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    cache_resp_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      resp_cnt++;
      if (expected_resp.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected result data=%h hit=%b done=%b", $time, read_data_o, hit_o,
                 done_code_o);
      end else begin
        exp_r = expected_resp.pop_front();
        if (read_data_o !== exp_r.data) begin
          error_cnt++;
          $display("%0t: read_data expected %h actual %h", $time, exp_r.data, read_data_o);
        end
        if (hit_o !== exp_r.hit) begin
          error_cnt++;
          $display("%0t: hit expected %b actual %b", $time, exp_r.hit, hit_o);
        end
        if (done_code_o !== exp_r.done) begin
          error_cnt++;
          $display("%0t: done_code expected %b actual %b", $time, exp_r.done, done_code_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random content: most addresses fall in a few sets and a dozen tags so
  // that hits, refills and evictions all happen; the rest are full range.
  // ---------------------------------------------------------------------------
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    logic [SET_BITS-1:0] set_v;
    logic [TAG_W-1:0]    tag_v;
    int                  tag_sel;
    if ($urandom_range(99) >= 85) return $urandom;
    case ($urandom_range(3))
      0:       set_v = '0;
      1:       set_v = SET_BITS'(1);
      2:       set_v = SET_BITS'(SETS / 2);
      default: set_v = '1;
    endcase
    tag_sel = $urandom_range(11);
    case (tag_sel)
      8:       tag_v = TAG_W'(8);       // first tag beyond the cache size
      9:       tag_v = TAG_W'('h12345);
      10:      tag_v = TAG_W'(1) << (TAG_W - 1);
      11:      tag_v = '1;
      default: tag_v = TAG_W'(tag_sel);
    endcase
    return {tag_v, set_v, OFF_BITS'($urandom_range(LINE_BYTES - 1))};
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_data();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Write then read back, a never-written word of a hit line, data extremes.
  task automatic test_basic_hit_miss();
    send_req(REQ_WRITE, 32'h0000_0000, 32'h7FFF_FFFF, 32'h1111_1111);
    send_req(REQ_READ,  32'h0000_0000, 32'h0,         32'h2222_2222);
    send_req(REQ_READ,  32'h0000_0004, 32'h0,         32'h3333_3333);
    send_req(REQ_READ,  32'h0000_7FE0, 32'h0,         32'h8000_0000);
    send_req(REQ_READ,  32'h0000_7FFC, 32'h0,         32'hFFFF_FFFF);
    send_req(REQ_WRITE, 32'h0000_7FFF, 32'h8000_0000, 32'h0);
    send_req(REQ_READ,  32'h0000_7FFC, 32'h0,         32'h4444_4444);
  endtask

  // Reads at or above the cache size still allocate but return zero.
  task automatic test_high_address();
    send_req(REQ_READ,  32'hFFFF_FFFC, 32'h0,         32'h5555_5555);
    send_req(REQ_READ,  32'hFFFF_FFFF, 32'h0,         32'hAAAA_AAAA);
    send_req(REQ_WRITE, 32'hFFFF_FFFC, 32'h8000_0000, 32'h0);
    send_req(REQ_READ,  32'h0000_8000, 32'h0,         32'hFFFF_FFFF);
    send_req(REQ_READ,  32'h0000_8000, 32'h0,         32'h0);
  endtask

  // Nine tags into one set: fills every way, then forces a replacement.
  task automatic test_eviction();
    for (int t = 0; t <= WAYS; t++) begin
      send_req(REQ_WRITE, (32'(t) << (OFF_BITS + SET_BITS)) | (32'(1) << OFF_BITS),
               32'hC0DE_0000 | 32'(t), 32'h0);
    end
    send_req(REQ_READ, 32'(1) << OFF_BITS, 32'h0, 32'hDEAD_BEEF);
    send_req(REQ_READ, (32'(WAYS) << (OFF_BITS + SET_BITS)) | (32'(1) << OFF_BITS), 32'h0,
             32'h0BAD_F00D);
  endtask

  task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      send_req(logic'($urandom_range(1)), pick_addr(), pick_data(), pick_data());
    end
    drain_results();
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so
  // the block backs up and stalls its input; then the sender pauses.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    for (int k = 0; k < 16; k++) begin
      send_req(logic'($urandom_range(1)), pick_addr(), pick_data(), pick_data());
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_READ;
    address_i      = '0;
    write_data_i   = '0;
    fill_data_i    = '0;
    out_stall_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    error_cnt      = 0;
    cycle_cnt      = 0;
    read_cnt       = 0;
    write_cnt      = 0;
    hit_cnt        = 0;
    high_read_cnt  = 0;
    resp_cnt       = 0;
    for (int w = 0; w < WAYS; w++) begin
      for (int s = 0; s < SETS; s++) begin
        shadow_valid[w][s] = 1'b0;
        shadow_tag[w][s]   = '0;
        shadow_age[w][s]   = '0;
        for (int d = 0; d < WORDS; d++) shadow_word[w][s][d] = '0;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_hit_miss();
    test_high_address();
    test_eviction();
    drain_results();

    test_random(150, 0, 0);
    test_random(150, 87, 0);
    test_backpressure();
    test_random(150, 0, 87);
    test_random(150, 35, 35);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_resp.size() != 0) begin
      error_cnt++;
      $display("%0t: %0d expected results never arrived", $time, expected_resp.size());
    end

    $display("Covered %0d requests (%0d reads, %0d writes), %0d hits, %0d misses,",
             read_cnt + write_cnt, read_cnt, write_cnt, hit_cnt,
             read_cnt + write_cnt - hit_cnt);
    $display("%0d reads beyond cache size, %0d results checked, %0d errors.", high_read_cnt,
             resp_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sacla_pkg.sv
src/sacla_ram.sv
src/sacla_lookup.sv
src/set_assoc_cache_lru_age.sv
tb/tb_set_assoc_cache_lru_age.sv
